/* hw/rtl/rev13_pkg.sv */
// Shared types and constants for the 5/3 predict-only row analysis block.
package rev13_pkg;

	localparam int DATA_W     = 32;
	localparam int LW_W       = 13;
	localparam int OPQ_DEPTH  = 4;
	localparam int RESQ_DEPTH = 4;

	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_FIRST_IS_LOW = 1'b1;

	localparam logic BAND_LOW  = 1'b0;
	localparam logic BAND_HIGH = 1'b1;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(2);

	typedef struct packed {
		logic              hi_en;
		logic              lo_en;
		logic              hi_end;
		logic              lo_end;
		logic [DATA_W-1:0] hi_h;
		logic [DATA_W-1:0] hi_avg;
		logic [DATA_W-1:0] lo_val;
	} op_t;

	typedef struct packed {
		logic              band;
		logic [DATA_W-1:0] coeff;
		logic              row_end;
	} res_t;

endpackage

/* hw/rtl/rev13_fifo.sv */
// Small register-based queue with fall-through head.
module rev13_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/rev13_front.sv */
// Front end: row position, phase, held samples and neighbour average.
module rev13_front #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rev13_pkg::LW_W-1:0]  line_width,
	input  logic                        first_is_low,
	input  logic                        push,
	input  logic [rev13_pkg::DATA_W-1:0] sample,
	output logic                        full,
	output logic                        op_wr,
	output rev13_pkg::op_t              op,
	input  logic                        op_full
);
	import rev13_pkg::*;

	localparam int POS_W = $clog2(MAX_WIDTH);

	logic [DATA_W-1:0] held_low_q, held_high_q;
	logic [POS_W-1:0]  row_pos_q;
	logic [31:0]       w_eff;
	logic              accept, last, low;
	logic [DATA_W-1:0] nb_a, nb_b;
	logic [DATA_W:0]   nb_sum;

	always_comb begin
		w_eff = 32'(line_width);
		if (w_eff < 32'd2) begin
			w_eff = 32'd2;
		end
		if (w_eff > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end
	end

	assign full   = op_full;
	assign accept = push && !op_full;
	assign last   = (32'(row_pos_q) + 32'd1) >= w_eff;
	assign low    = row_pos_q[0] ^ first_is_low;

	always_comb begin
		if (low) begin
			nb_a = (row_pos_q == POS_W'(1)) ? sample : held_low_q;
			nb_b = sample;
		end else begin
			nb_a = held_low_q;
			nb_b = held_low_q;
		end
		nb_sum = {nb_a[DATA_W-1], nb_a} + {nb_b[DATA_W-1], nb_b};

		op.hi_en  = low ? (row_pos_q != '0) : last;
		op.lo_en  = low;
		op.hi_end = !low;
		op.lo_end = last;
		op.hi_h   = low ? held_high_q : sample;
		op.hi_avg = nb_sum[DATA_W:1];
		op.lo_val = sample;
	end

	assign op_wr = accept && (op.hi_en || op.lo_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_low_q  <= '0;
			held_high_q <= '0;
			row_pos_q   <= '0;
		end else if (accept) begin
			if (low) begin
				held_low_q <= sample;
			end else begin
				held_high_q <= sample;
			end
			row_pos_q <= last ? '0 : row_pos_q + 1'b1;
		end
	end

endmodule

/* hw/rtl/rev13_back.sv */
// Back end: drains queued operations into one result per cycle while the result queue has room.
module rev13_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rev13_pkg::op_t op,
	input  logic           op_empty,
	output logic           op_pop,
	output logic           res_wr,
	output rev13_pkg::res_t res,
	input  logic           res_full
);
	import rev13_pkg::*;

	logic step_q;
	logic emit_hi;

	assign emit_hi = op.hi_en && !step_q;
	assign res_wr  = !op_empty && !res_full;
	assign op_pop  = res_wr && !(emit_hi && op.lo_en);

	always_comb begin
		res.band    = emit_hi ? BAND_HIGH : BAND_LOW;
		res.coeff   = emit_hi ? (op.hi_h - op.hi_avg) : op.lo_val;
		res.row_end = emit_hi ? op.hi_end : op.lo_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
		end else if (res_wr) begin
			step_q <= emit_hi && op.lo_en;
		end
	end

	a_step_pair: assert property (@(posedge clk) disable iff (!arst_n)
		step_q |-> (!op_empty && op.hi_en && op.lo_en))
		else $error("second step without a two-result operation");

	a_pop_writes: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> res_wr)
		else $error("operation retired without a result");

	a_high_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && res.row_end && res.band == BAND_HIGH) |-> (op.hi_end && !op.lo_en))
		else $error("high-pass row end from a low-phase operation");

endmodule

/* hw/rtl/rev13_dwt_row_analysis.sv */
// Top level of the 5/3 predict-only row analysis block.
// Takes one sample per cycle when the result side keeps up; each sample is
// classified combinationally and queued, and the back end writes one result per
// cycle while the result queue has room, so a sample that yields two results
// (high then low) occupies the back end for both writes. Average throughput is one
// sample per cycle, set by the single result write port; a sample's results pass
// through the operation queue and the result queue before reaching the result ports.
module rev13_dwt_row_analysis #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	input  logic signed [31:0] sample,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output logic               band,
	output logic signed [31:0] coeff,
	output logic               row_end
);
	import rev13_pkg::*;

	logic [LW_W-1:0] line_width_q;
	logic            first_is_low_q;
	logic            cfg_wr;
	op_t             op_in, op_out;
	logic            op_wr, op_full, op_empty, op_pop;
	res_t            res_in, res_out;
	logic            res_wr, res_full;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			first_is_low_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LINE_WIDTH:   line_width_q   <= pwdata[LW_W-1:0];
				REG_FIRST_IS_LOW: first_is_low_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LINE_WIDTH:   prdata = {{(32-LW_W){1'b0}}, line_width_q};
			REG_FIRST_IS_LOW: prdata = {31'b0, first_is_low_q};
			default:          prdata = '0;
		endcase
	end

	rev13_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_width  (line_width_q),
		.first_is_low(first_is_low_q),
		.push        (push),
		.sample      (sample),
		.full        (full),
		.op_wr       (op_wr),
		.op          (op_in),
		.op_full     (op_full)
	);

	rev13_fifo #(.WIDTH($bits(op_t)), .DEPTH(OPQ_DEPTH)) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (op_wr),
		.wr_data(op_in),
		.full   (op_full),
		.rd     (op_pop),
		.rd_data(op_out),
		.empty  (op_empty)
	);

	rev13_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op_out),
		.op_empty(op_empty),
		.op_pop  (op_pop),
		.res_wr  (res_wr),
		.res     (res_in),
		.res_full(res_full)
	);

	rev13_fifo #(.WIDTH($bits(res_t)), .DEPTH(RESQ_DEPTH)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wr_data(res_in),
		.full   (res_full),
		.rd     (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign band    = res_out.band;
	assign coeff   = res_out.coeff;
	assign row_end = res_out.row_end;

endmodule
